@@ hdl/sf3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sf3_pkg
// Shared types and constants of the spring force pipeline.
// ----------------------------------------------------------------------------
package sf3_pkg;

    localparam int AXES         = 3;
    localparam int ROOT_BITS    = 34;
    localparam int RAD_BITS     = 2 * ROOT_BITS;
    localparam int REM_BITS     = ROOT_BITS + 3;
    localparam int SUM_BITS     = 66;
    localparam int TAYLOR_TERMS = 8;

    localparam int DIST_LAT  = 3 + ROOT_BITS;
    localparam int PULSE_LAT = 8 + 3 * TAYLOR_TERMS;
    localparam int REST_DLY  = DIST_LAT - PULSE_LAT;
    localparam int TOTAL_LAT = DIST_LAT + 3;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [63:0] INV_TWO_PI  = 64'h28BE_60DB_9391_054A;

    localparam logic [2:0] REG_STIFFNESS = 3'd0;
    localparam logic [2:0] REG_REST_LEN  = 3'd1;
    localparam logic [2:0] REG_PULSE_AMP = 3'd2;
    localparam logic [2:0] REG_PULSE_PH  = 3'd3;
    localparam logic [2:0] REG_PULSE_FRQ = 3'd4;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [RAD_BITS-1:0]  rad;
    } sqrt_t;

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] t;
    } tay_t;

endpackage

@@ hdl/sf3_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sf3_sqrt_cell
// One root bit of a restoring integer square root.
// ----------------------------------------------------------------------------
module sf3_sqrt_cell (
    input  logic          aclk,
    input  logic          en,
    input  sf3_pkg::sqrt_t in_s,
    output sf3_pkg::sqrt_t out_s
);

    sf3_pkg::sqrt_t                 out_reg;
    logic [sf3_pkg::REM_BITS-1:0]   rem_s;
    logic [sf3_pkg::REM_BITS-1:0]   trial;

    assign rem_s = {in_s.rem[sf3_pkg::REM_BITS-3:0],
                    in_s.rad[sf3_pkg::RAD_BITS-1 -: 2]};
    assign trial = {1'b0, in_s.root, 2'b01};

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.rad <= {in_s.rad[sf3_pkg::RAD_BITS-3:0], 2'b00};
            if (rem_s >= trial) begin
                out_reg.rem  <= rem_s - trial;
                out_reg.root <= {in_s.root[sf3_pkg::ROOT_BITS-2:0], 1'b1};
            end else begin
                out_reg.rem  <= rem_s;
                out_reg.root <= {in_s.root[sf3_pkg::ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    assign out_s = out_reg;

endmodule

@@ hdl/sf3_taylor_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sf3_taylor_cell
// One nested sine series step: t = 1 - ((x2 * t) >> 30) / K, in three stages.
// ----------------------------------------------------------------------------
module sf3_taylor_cell #(
    parameter int K = 6
) (
    input  logic          aclk,
    input  logic          en,
    input  sf3_pkg::tay_t in_s,
    output sf3_pkg::tay_t out_s
);

    localparam logic [31:0] RECIP = 32'((64'd1 << 34) / K);
    localparam logic [8:0]  KV    = 9'(K);

    logic [30:0] xa_reg, xb_reg;
    logic [31:0] x2a_reg, x2b_reg;
    logic [32:0] pa_reg, pb_reg;
    logic [30:0] q0_reg;
    sf3_pkg::tay_t out_reg;

    logic [62:0] prod_a;
    logic [64:0] prod_b;
    logic [39:0] qk;
    logic [39:0] rem;
    logic [30:0] q;

    assign prod_a = 63'(in_s.x2) * 63'(in_s.t);
    assign prod_b = 65'(pa_reg) * 65'(RECIP);
    assign qk     = 40'(q0_reg) * 40'(KV);
    assign rem    = 40'(pb_reg) - qk;
    assign q      = q0_reg + 31'(rem >= 40'(KV));

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg  <= in_s.x;
            x2a_reg <= in_s.x2;
            pa_reg  <= prod_a[62:30];
            xb_reg  <= xa_reg;
            x2b_reg <= x2a_reg;
            pb_reg  <= pa_reg;
            q0_reg  <= prod_b[64:34];
            out_reg.x  <= xb_reg;
            out_reg.x2 <= x2b_reg;
            out_reg.t  <= sf3_pkg::ONE_Q30 - q;
        end
    end

    assign out_s = out_reg;

endmodule

@@ hdl/sf3_pulse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sf3_pulse
// Pulse term |amp * sin(freq * time + phase)| / 2, fully pipelined.
// ----------------------------------------------------------------------------
module sf3_pulse #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] sim_time,
    input  logic [31:0] amplitude,
    input  logic [31:0] phase,
    input  logic [31:0] frequency,
    output logic [31:0] extra
);

    logic [63:0] prod1_reg;
    logic        fneg_reg;
    logic [63:0] amag_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [31:0] turn_reg;
    logic [30:0] x_reg;
    sf3_pkg::tay_t tay_s [sf3_pkg::TAYLOR_TERMS+1];
    logic [30:0] s_reg;
    logic [31:0] extra_reg;

    logic [31:0]        fmag;
    logic [31:0]        amp_mag;
    logic [63:0]        sh;
    logic signed [65:0] ang;
    logic [127:0]       full;
    logic [30:0]        frac;
    logic [61:0]        xprod;
    logic [61:0]        x2prod;
    logic [31:0]        x2;
    logic [61:0]        sprod;
    logic [62:0]        eprod;

    assign fmag    = frequency[31] ? 32'(-frequency) : frequency;
    assign amp_mag = amplitude[31] ? 32'(-amplitude) : amplitude;
    assign sh      = prod1_reg >> FRAC_BITS;
    assign ang     = (fneg_reg ? -$signed({2'b00, sh}) : $signed({2'b00, sh}))
                     + 66'($signed(phase));
    assign full    = {64'd0, p00_reg} + ({64'd0, p01_reg} << 32)
                     + ({64'd0, p10_reg} << 32) + {p11_reg, 64'd0};
    assign frac    = turn_reg[30] ? sf3_pkg::ONE_Q30 - {1'b0, turn_reg[29:0]}
                                  : {1'b0, turn_reg[29:0]};
    assign xprod   = 62'(frac) * 62'(sf3_pkg::HALF_PI_Q30);
    assign x2prod  = 62'(x_reg) * 62'(x_reg);
    assign x2      = x2prod[61:30];
    assign sprod   = 62'(tay_s[sf3_pkg::TAYLOR_TERMS].x)
                     * 62'(tay_s[sf3_pkg::TAYLOR_TERMS].t);
    assign eprod   = 63'(amp_mag) * 63'(s_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg <= 64'(fmag) * 64'(sim_time);
            fneg_reg  <= frequency[31];
            amag_reg  <= ang[65] ? 64'(-ang) : ang[63:0];
            p00_reg   <= 64'(amag_reg[31:0])  * 64'(sf3_pkg::INV_TWO_PI[31:0]);
            p01_reg   <= 64'(amag_reg[31:0])  * 64'(sf3_pkg::INV_TWO_PI[63:32]);
            p10_reg   <= 64'(amag_reg[63:32]) * 64'(sf3_pkg::INV_TWO_PI[31:0]);
            p11_reg   <= 64'(amag_reg[63:32]) * 64'(sf3_pkg::INV_TWO_PI[63:32]);
            turn_reg  <= full[32+FRAC_BITS +: 32];
            x_reg     <= xprod[60:30];
            tay_s[0].x  <= x_reg;
            tay_s[0].x2 <= x2;
            tay_s[0].t  <= sf3_pkg::ONE_Q30;
            s_reg     <= (sprod[61:30] > 32'(sf3_pkg::ONE_Q30)) ? sf3_pkg::ONE_Q30
                                                               : sprod[60:30];
            extra_reg <= eprod[62:31];
        end
    end

    for (genvar j = 0; j < sf3_pkg::TAYLOR_TERMS; j++) begin : g_tay
        localparam int N = sf3_pkg::TAYLOR_TERMS - j;
        sf3_taylor_cell #(.K(2 * N * (2 * N + 1))) u_cell (
            .aclk  (aclk),
            .en    (en),
            .in_s  (tay_s[j]),
            .out_s (tay_s[j+1])
        );
    end

    assign extra = extra_reg;

endmodule

@@ hdl/spring_force_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_force_3d
// Hooke spring force between two masses, optional pulsing rest length.
//
// Input word: both mass positions, sim time and pulse flag (s_ valid/ready).
// Output word: saturated Q16.16 force and saturation flag (m_ valid/ready).
// Registers (APB, byte address 4*i): stiffness, rest_length, pulse_amplitude,
// pulse_phase, pulse_frequency; write them only while the pipe is empty.
// A word passes the difference, squaring and sum stages, the 34-cell square
// root chain and the force stages. Throughput is one word per cycle unless
// the receiver stalls. The whole pipe advances as one; when the receiver
// stalls with a word waiting, s_ready drops and every stage holds until
// m_ready returns. Reset empties the pipe and loads the register defaults
// (stiffness and rest length 1.0, pulse registers 0).
// ----------------------------------------------------------------------------
module spring_force_3d #(
    parameter int FRAC_BITS  = 16,
    parameter int DIMENSIONS = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_first_x,
    input  logic [31:0] s_first_y,
    input  logic [31:0] s_first_z,
    input  logic [31:0] s_second_x,
    input  logic [31:0] s_second_y,
    input  logic [31:0] s_second_z,
    input  logic [31:0] s_sim_time,
    input  logic        s_pulse_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_spring_force,
    output logic        m_force_saturated
);

    localparam int AX = sf3_pkg::AXES;

    logic [31:0] stiff_reg, rest_len_reg, amp_reg, phase_reg, freq_reg;
    logic [sf3_pkg::TOTAL_LAT-1:0] vld_reg;
    logic        mode_reg [sf3_pkg::PULSE_LAT];
    logic [32:0] dmag_reg [AX];
    logic [65:0] sq_reg [AX];
    logic [sf3_pkg::SUM_BITS-1:0] sum_reg;
    logic [32:0] rest_reg [sf3_pkg::REST_DLY];
    logic        neg_reg;
    logic [34:0] fmag_reg;
    logic        fneg_reg;
    logic [66:0] fprod_reg;
    logic [31:0] force_reg;
    logic        sat_reg;

    logic        en;
    logic [2:0]  idx;
    logic [31:0] first_a  [AX];
    logic [31:0] second_a [AX];
    logic signed [32:0] dif [AX];
    logic [31:0] extra;
    sf3_pkg::sqrt_t sq_s [sf3_pkg::ROOT_BITS+1];
    logic signed [35:0] diff;
    logic [66:0] fshift;

    assign en      = ~vld_reg[sf3_pkg::TOTAL_LAT-1] | m_ready;
    assign s_ready = en;
    assign pready  = 1'b1;
    assign idx     = paddr[4:2];

    assign first_a[0]  = s_first_x;
    assign first_a[1]  = s_first_y;
    assign first_a[2]  = s_first_z;
    assign second_a[0] = s_second_x;
    assign second_a[1] = s_second_y;
    assign second_a[2] = s_second_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stiff_reg    <= 32'h0001_0000;
            rest_len_reg <= 32'h0001_0000;
            amp_reg      <= '0;
            phase_reg    <= '0;
            freq_reg     <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                sf3_pkg::REG_STIFFNESS: stiff_reg    <= pwdata;
                sf3_pkg::REG_REST_LEN:  rest_len_reg <= pwdata;
                sf3_pkg::REG_PULSE_AMP: amp_reg      <= pwdata;
                sf3_pkg::REG_PULSE_PH:  phase_reg    <= pwdata;
                sf3_pkg::REG_PULSE_FRQ: freq_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            sf3_pkg::REG_STIFFNESS: prdata = stiff_reg;
            sf3_pkg::REG_REST_LEN:  prdata = rest_len_reg;
            sf3_pkg::REG_PULSE_AMP: prdata = amp_reg;
            sf3_pkg::REG_PULSE_PH:  prdata = phase_reg;
            sf3_pkg::REG_PULSE_FRQ: prdata = freq_reg;
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[sf3_pkg::TOTAL_LAT-2:0], s_valid};
        end
    end

    for (genvar i = 0; i < AX; i++) begin : g_axis
        assign dif[i] = $signed({first_a[i][31], first_a[i]})
                        - $signed({second_a[i][31], second_a[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                if (i < DIMENSIONS) begin
                    dmag_reg[i] <= dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
                end else begin
                    dmag_reg[i] <= '0;
                end
                sq_reg[i] <= 66'(dmag_reg[i]) * 66'(dmag_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign sq_s[0].rem  = '0;
    assign sq_s[0].root = '0;
    assign sq_s[0].rad  = sf3_pkg::RAD_BITS'(sum_reg);

    for (genvar b = 0; b < sf3_pkg::ROOT_BITS; b++) begin : g_sqrt
        sf3_sqrt_cell u_cell (
            .aclk  (aclk),
            .en    (en),
            .in_s  (sq_s[b]),
            .out_s (sq_s[b+1])
        );
    end

    sf3_pulse #(.FRAC_BITS(FRAC_BITS)) u_pulse (
        .aclk      (aclk),
        .en        (en),
        .sim_time  (s_sim_time),
        .amplitude (amp_reg),
        .phase     (phase_reg),
        .frequency (freq_reg),
        .extra     (extra)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            mode_reg[0] <= s_pulse_mode;
            for (int k = 1; k < sf3_pkg::PULSE_LAT; k++) begin
                mode_reg[k] <= mode_reg[k-1];
            end
            rest_reg[0] <= 33'(rest_len_reg)
                           + (mode_reg[sf3_pkg::PULSE_LAT-1] ? 33'(extra) : 33'd0);
            for (int k = 1; k < sf3_pkg::REST_DLY; k++) begin
                rest_reg[k] <= rest_reg[k-1];
            end
        end
    end

    assign diff = $signed({2'b00, sq_s[sf3_pkg::ROOT_BITS].root})
                  - $signed({3'b000, rest_reg[sf3_pkg::REST_DLY-1]});
    assign fshift = fprod_reg >> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg   <= diff[35];
            fmag_reg  <= diff[35] ? 35'(-diff) : 35'(diff);
            fneg_reg  <= neg_reg;
            fprod_reg <= 67'(fmag_reg) * 67'(stiff_reg);
            if (fneg_reg) begin
                if (fshift > 67'h8000_0000) begin
                    force_reg <= 32'h8000_0000;
                    sat_reg   <= 1'b1;
                end else begin
                    force_reg <= 32'(-fshift);
                    sat_reg   <= 1'b0;
                end
            end else begin
                if (fshift > 67'h7FFF_FFFF) begin
                    force_reg <= 32'h7FFF_FFFF;
                    sat_reg   <= 1'b1;
                end else begin
                    force_reg <= fshift[31:0];
                    sat_reg   <= 1'b0;
                end
            end
        end
    end

    assign m_valid           = vld_reg[sf3_pkg::TOTAL_LAT-1];
    assign m_spring_force    = force_reg;
    assign m_force_saturated = sat_reg;

endmodule
